>>> sv/bls_pkg.sv
// Shared types and constants for the Bresenham line stepper.
// No dependencies; every other file of the block imports this package.
package bls_pkg;

   localparam int COORD_BITS  = 12;
   localparam int COLOR_BITS  = 32;
   // Decision value needs two bits of growth plus a sign over the coordinates.
   localparam int ERR_BITS    = COORD_BITS + 3;
   localparam int Q_DEPTH     = 2;
   localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef struct packed {
      op_type                cmd;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
      logic [COLOR_BITS-1:0] pixel_color;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [COLOR_BITS-1:0] color_out;
      logic                  last_pixel;
   } rsp_type;

   // Classified request as it sits in the command queue.
   typedef struct packed {
      op_type                op;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] abs_dx;
      logic [COORD_BITS-1:0] abs_dy;
      logic                  x_neg;
      logic                  y_neg;
      logic [COLOR_BITS-1:0] color;
   } cmd_type;

   // Handshake between command queue and stepper.
   typedef struct packed {
      logic valid;
   } cq_status_type;

   typedef struct packed {
      logic pop;
   } cq_ctrl_type;

endpackage

>>> sv/bls_front.sv
// Front end: decodes a request and works out step signs and absolute deltas.
// Depends on bls_pkg.
module bls_front (
   input  bls_pkg::req_type req,
   output bls_pkg::cmd_type cmd
);
   import bls_pkg::*;

   logic [COORD_BITS:0] dx_fwd;
   logic [COORD_BITS:0] dx_rev;
   logic [COORD_BITS:0] dy_fwd;
   logic [COORD_BITS:0] dy_rev;

   // Both directions in parallel; the borrow of the forward one picks the sign.
   assign dx_fwd = {1'b0, req.end_x} - {1'b0, req.start_x};
   assign dx_rev = {1'b0, req.start_x} - {1'b0, req.end_x};
   assign dy_fwd = {1'b0, req.end_y} - {1'b0, req.start_y};
   assign dy_rev = {1'b0, req.start_y} - {1'b0, req.end_y};

   always_comb begin
      cmd.op      = req.cmd;
      cmd.start_x = req.start_x;
      cmd.start_y = req.start_y;
      cmd.x_neg   = dx_fwd[COORD_BITS];
      cmd.y_neg   = dy_fwd[COORD_BITS];
      cmd.abs_dx  = dx_fwd[COORD_BITS] ? dx_rev[COORD_BITS-1:0] : dx_fwd[COORD_BITS-1:0];
      cmd.abs_dy  = dy_fwd[COORD_BITS] ? dy_rev[COORD_BITS-1:0] : dy_fwd[COORD_BITS-1:0];
      cmd.color   = req.pixel_color;
   end

endmodule

>>> sv/bls_cmd_queue.sv
// Short command queue that decouples the front end from the stepper.
// Depends on bls_pkg.
module bls_cmd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  bls_pkg::cmd_type       push_data,
   output bls_pkg::cq_status_type status,
   input  bls_pkg::cq_ctrl_type   ctrl,
   output bls_pkg::cmd_type       head
);
   import bls_pkg::*;

   cmd_type               mem_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  do_push;
   logic                  do_pop;

   assign full         = (cnt_ff == Q_CNT_BITS'(Q_DEPTH));
   assign status.valid = (cnt_ff != '0);
   assign head         = mem_ff[rd_ptr_ff];
   assign do_push      = push && !full;
   assign do_pop       = ctrl.pop && status.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + Q_CNT_BITS'(do_push) - Q_CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/bls_back.sv
// Back end: line setup, per-pixel Bresenham step and the result queue.
// Depends on bls_pkg.
module bls_back (
   input  logic                   clock,
   input  logic                   reset,
   input  bls_pkg::cq_status_type cq_status,
   output bls_pkg::cq_ctrl_type   cq_ctrl,
   input  bls_pkg::cmd_type       cmd,
   output logic                   empty,
   input  logic                   pop,
   output bls_pkg::rsp_type       rsp_data
);
   import bls_pkg::*;

   // Line state.
   logic [COORD_BITS-1:0]      x_ff, x_in;
   logic [COORD_BITS-1:0]      y_ff, y_in;
   logic [COORD_BITS-1:0]      steps_ff, steps_in;
   logic signed [ERR_BITS-1:0] err_ff, err_in;
   logic [COORD_BITS:0]        inc_a_ff, inc_a_in;
   logic signed [ERR_BITS-1:0] inc_b_ff, inc_b_in;
   logic                       x_neg_ff, x_neg_in;
   logic                       y_neg_ff, y_neg_in;
   logic                       y_major_ff, y_major_in;
   logic [COLOR_BITS-1:0]      color_ff, color_in;
   logic                       busy_ff, busy_in;

   // Result queue.
   rsp_type               oq_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] oq_wr_ff, oq_rd_ff;
   logic [Q_CNT_BITS-1:0] oq_cnt_ff, oq_cnt_in;
   logic                  oq_space;
   logic                  oq_pop;

   // Setup terms.
   logic [COORD_BITS:0]        d_yx;
   logic [COORD_BITS:0]        d_xy;
   logic                       ld_y_major;
   logic [COORD_BITS-1:0]      ld_major;
   logic [COORD_BITS-1:0]      ld_minor;
   logic signed [ERR_BITS-1:0] ei_xmaj;
   logic signed [ERR_BITS-1:0] ei_ymaj;

   logic    is_load;
   logic    take;
   logic    emit;
   logic    move_x;
   logic    move_y;
   rsp_type pix;

   assign oq_space = (oq_cnt_ff != Q_CNT_BITS'(Q_DEPTH));
   assign oq_pop   = pop && !empty;
   assign empty    = (oq_cnt_ff == '0);
   assign rsp_data = oq_ff[oq_rd_ff];

   assign is_load = (cmd.op == OP_LOAD);
   // An advance with no active line is dropped without needing result space.
   assign take    = cq_status.valid && (oq_space || (!is_load && !busy_ff));
   assign emit    = take && (is_load || busy_ff);
   assign cq_ctrl.pop = take;

   assign d_yx       = {1'b0, cmd.abs_dy} - {1'b0, cmd.abs_dx};
   assign d_xy       = {1'b0, cmd.abs_dx} - {1'b0, cmd.abs_dy};
   assign ld_y_major = d_xy[COORD_BITS];
   assign ld_major   = ld_y_major ? cmd.abs_dy : cmd.abs_dx;
   assign ld_minor   = ld_y_major ? cmd.abs_dx : cmd.abs_dy;
   assign ei_xmaj    = {2'b00, cmd.abs_dy, 1'b0} - {3'b000, cmd.abs_dx};
   assign ei_ymaj    = {2'b00, cmd.abs_dx, 1'b0} - {3'b000, cmd.abs_dy};

   // Minor axis moves too once the decision value is not negative.
   assign move_x = !err_ff[ERR_BITS-1] || !y_major_ff;
   assign move_y = !err_ff[ERR_BITS-1] || y_major_ff;

   always_comb begin
      x_in       = x_ff;
      y_in       = y_ff;
      steps_in   = steps_ff;
      err_in     = err_ff;
      inc_a_in   = inc_a_ff;
      inc_b_in   = inc_b_ff;
      x_neg_in   = x_neg_ff;
      y_neg_in   = y_neg_ff;
      y_major_in = y_major_ff;
      color_in   = color_ff;
      busy_in    = busy_ff;
      pix        = '0;
      if (take && is_load) begin
         x_in       = cmd.start_x;
         y_in       = cmd.start_y;
         steps_in   = ld_major;
         err_in     = ld_y_major ? ei_ymaj : ei_xmaj;
         inc_a_in   = {ld_minor, 1'b0};
         // 2*(minor - major), always zero or negative
         inc_b_in   = ld_y_major ? {d_xy[COORD_BITS], d_xy, 1'b0}
                                 : {d_yx[COORD_BITS], d_yx, 1'b0};
         x_neg_in   = cmd.x_neg;
         y_neg_in   = cmd.y_neg;
         y_major_in = ld_y_major;
         color_in   = cmd.color;
         busy_in    = (ld_major != '0);
         pix.pixel_x    = cmd.start_x;
         pix.pixel_y    = cmd.start_y;
         pix.color_out  = cmd.color;
         pix.last_pixel = (ld_major == '0);
      end else if (take && busy_ff) begin
         if (move_x) begin
            x_in = x_neg_ff ? x_ff - 1'b1 : x_ff + 1'b1;
         end
         if (move_y) begin
            y_in = y_neg_ff ? y_ff - 1'b1 : y_ff + 1'b1;
         end
         err_in   = err_ff + (err_ff[ERR_BITS-1] ?
                              $signed({{(ERR_BITS-COORD_BITS-1){1'b0}}, inc_a_ff}) :
                              inc_b_ff);
         steps_in = steps_ff - 1'b1;
         busy_in  = (steps_ff != COORD_BITS'(1));
         pix.pixel_x    = x_in;
         pix.pixel_y    = y_in;
         pix.color_out  = color_ff;
         pix.last_pixel = (steps_ff == COORD_BITS'(1));
      end
      oq_cnt_in = oq_cnt_ff + Q_CNT_BITS'(emit) - Q_CNT_BITS'(oq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff       <= '0;
         y_ff       <= '0;
         steps_ff   <= '0;
         err_ff     <= '0;
         inc_a_ff   <= '0;
         inc_b_ff   <= '0;
         x_neg_ff   <= 1'b0;
         y_neg_ff   <= 1'b0;
         y_major_ff <= 1'b0;
         color_ff   <= '0;
         busy_ff    <= 1'b0;
         oq_wr_ff   <= '0;
         oq_rd_ff   <= '0;
         oq_cnt_ff  <= '0;
      end else begin
         x_ff       <= x_in;
         y_ff       <= y_in;
         steps_ff   <= steps_in;
         err_ff     <= err_in;
         inc_a_ff   <= inc_a_in;
         inc_b_ff   <= inc_b_in;
         x_neg_ff   <= x_neg_in;
         y_neg_ff   <= y_neg_in;
         y_major_ff <= y_major_in;
         color_ff   <= color_in;
         busy_ff    <= busy_in;
         oq_cnt_ff  <= oq_cnt_in;
         if (emit) begin
            oq_wr_ff <= oq_wr_ff + 1'b1;
         end
         if (oq_pop) begin
            oq_rd_ff <= oq_rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         oq_ff[oq_wr_ff] <= pix;
      end
   end

   a_busy_has_steps: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (steps_ff != '0))
      else $error("active line with no steps left");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (emit && pix.last_pixel) |=> !busy_ff)
      else $error("line still active after its endpoint");

   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      oq_cnt_ff <= Q_CNT_BITS'(Q_DEPTH))
      else $error("result queue overflow");

   a_inc_b_nonpos: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (inc_b_ff <= 0))
      else $error("diagonal step term positive");

endmodule

>>> sv/bresenham_line_stepper.sv
// Top level of the Bresenham line stepper: front end, command queue, stepper.
// Depends on bls_pkg, bls_front, bls_cmd_queue and bls_back.
//
//   channel   ports                       direction   accepted when
//   request   push, full, req_data        in          push && !full
//   result    empty, pop, rsp_data        out         pop && !empty
//
// One request per cycle sustained while the result queue has space; a load or
// an advance on an active line is written into the command queue when accepted,
// then the stepper's registered update writes its pixel into the result queue.
// The rate is set by the stepper's error update, one add per pixel.
// Reset is synchronous; it empties both queues and ends any active line.
// A stalled result side fills the two-entry result queue, then the command
// queue, and only then is full raised.
module bresenham_line_stepper (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  bls_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output bls_pkg::rsp_type rsp_data
);
   import bls_pkg::*;

   cmd_type       front_cmd;
   cmd_type       head_cmd;
   cq_status_type cq_status;
   cq_ctrl_type   cq_ctrl;

   // Classify the request: deltas and step signs, ready for line setup.
   bls_front u_front (
      .req (req_data),
      .cmd (front_cmd)
   );

   // Hold classified requests until the stepper can take them.
   bls_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .push_data (front_cmd),
      .status    (cq_status),
      .ctrl      (cq_ctrl),
      .head      (head_cmd)
   );

   // Set up lines, advance one pixel per command, queue the pixels.
   bls_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cq_status (cq_status),
      .cq_ctrl   (cq_ctrl),
      .cmd       (head_cmd),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/bls_line_checker.sv
// Scoreboard for the Bresenham line stepper: watches both channels, predicts pixels.
// Depends on bls_pkg for the request and result types.
module bls_line_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             full,
   input  bls_pkg::req_type req_data,
   input  logic             empty,
   input  logic             pop,
   input  bls_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pixels_pending
);
   import bls_pkg::*;

   localparam int PRINT_CAP = 100;

   rsp_type               expected_pixels[$];

   // Rasterizer state as the predictor sees it.
   logic [COORD_BITS-1:0] pen_x;
   logic [COORD_BITS-1:0] pen_y;
   logic [COORD_BITS-1:0] steps_to_go;
   logic [COORD_BITS-1:0] major_len;
   logic [COORD_BITS-1:0] minor_len;
   logic [COLOR_BITS-1:0] ink;
   int                    decision;
   bit                    x_back;
   bit                    y_back;
   bit                    steep;
   bit                    drawing;
   int                    pixel_index;

   initial begin
      error_count    = 0;
      pixels_pending = 0;
      pixel_index    = 0;
   end

   task automatic flag_error(input string msg);
      if (error_count < PRINT_CAP)
         $display("ERROR: pixel %0d: %s", pixel_index, msg);
      error_count++;
   endtask

   task automatic clear_line_state();
      pen_x       = '0;
      pen_y       = '0;
      steps_to_go = '0;
      major_len   = '0;
      minor_len   = '0;
      ink         = '0;
      decision    = 0;
      x_back      = 1'b0;
      y_back      = 1'b0;
      steep       = 1'b0;
      drawing     = 1'b0;
   endtask

   function automatic logic [COORD_BITS-1:0] nudge(input logic [COORD_BITS-1:0] c,
                                                   input bit back);
      return back ? c - 1'b1 : c + 1'b1;
   endfunction

   // Apply one request to the line state; return the pixel it draws, if any.
   task automatic trace_request(input req_type r, output bit emits, output rsp_type px);
      int dx;
      int dy;
      int adx;
      int ady;
      emits = 1'b1;
      if (r.cmd == OP_LOAD) begin
         dx          = int'(r.end_x) - int'(r.start_x);
         dy          = int'(r.end_y) - int'(r.start_y);
         x_back      = dx < 0;
         y_back      = dy < 0;
         adx         = x_back ? -dx : dx;
         ady         = y_back ? -dy : dy;
         steep       = ady > adx;
         major_len   = COORD_BITS'(steep ? ady : adx);
         minor_len   = COORD_BITS'(steep ? adx : ady);
         decision    = 2 * int'(minor_len) - int'(major_len);
         pen_x       = r.start_x;
         pen_y       = r.start_y;
         steps_to_go = major_len;
         ink         = r.pixel_color;
         drawing     = major_len != 0;
      end else if (!drawing) begin
         emits = 1'b0;
      end else begin
         if (decision < 0) begin
            if (steep)
               pen_y = nudge(pen_y, y_back);
            else
               pen_x = nudge(pen_x, x_back);
            decision += 2 * int'(minor_len);
         end else begin
            pen_x = nudge(pen_x, x_back);
            pen_y = nudge(pen_y, y_back);
            decision += 2 * int'(minor_len) - 2 * int'(major_len);
         end
         steps_to_go = steps_to_go - 1'b1;
         if (steps_to_go == 0)
            drawing = 1'b0;
      end
      px.pixel_x    = pen_x;
      px.pixel_y    = pen_y;
      px.color_out  = ink;
      px.last_pixel = steps_to_go == 0;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type px;
      bit      emits;
      if (reset) begin
         clear_line_state();
         expected_pixels.delete();
      end else begin
         // Check the result side first: a pixel cannot leave in the cycle its
         // request enters.
         if (pop && !empty) begin
            if (expected_pixels.size() == 0) begin
               flag_error($sformatf("got (%0d,%0d) with none expected",
                                    rsp_data.pixel_x, rsp_data.pixel_y));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.pixel_x !== want.pixel_x)
                  flag_error($sformatf("pixel_x %0d, expected %0d",
                                       rsp_data.pixel_x, want.pixel_x));
               if (rsp_data.pixel_y !== want.pixel_y)
                  flag_error($sformatf("pixel_y %0d, expected %0d",
                                       rsp_data.pixel_y, want.pixel_y));
               if (rsp_data.color_out !== want.color_out)
                  flag_error($sformatf("color_out %h, expected %h",
                                       rsp_data.color_out, want.color_out));
               if (rsp_data.last_pixel !== want.last_pixel)
                  flag_error($sformatf("last_pixel %b, expected %b",
                                       rsp_data.last_pixel, want.last_pixel));
            end
            pixel_index++;
         end
         if (push && !full) begin
            trace_request(req_data, emits, px);
            if (emits)
               expected_pixels.push_back(px);
         end
      end
      pixels_pending = expected_pixels.size();
   end

endmodule

>>> tb/tb_top.sv
// Top of the line stepper testbench: clock, reset, request and result traffic.
// Depends on bls_pkg, bresenham_line_stepper and bls_line_checker.
module tb_top;
   import bls_pkg::*;

   localparam int ITEM_TARGET = 1200;
   localparam int CALM_ITEMS  = 200;     // final stretch with no idling
   localparam int HOLD_CYCLES = 60;      // long result-side hold-off
   localparam int CYCLE_LIMIT = 300000;
   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
   localparam int DRAIN_WAIT  = 8;

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;

   int      error_count;
   int      pixels_pending;
   int      cycle_count;
   int      line_items;

   // Traffic shaping shared by the request and result processes.
   bit      calm;
   bit      tx_idling;
   int      tx_mode_left;
   bit      hold_off_request;

   bresenham_line_stepper dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   bls_line_checker pixel_checker (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data       (req_data),
      .empty          (empty),
      .pop            (pop),
      .rsp_data       (rsp_data),
      .error_count    (error_count),
      .pixels_pending (pixels_pending)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: stop a hung run well past the slowest legal finish.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Request builders
   // ---------------------------------------------------------------------------
   function automatic req_type load_request(input int sx, input int sy, input int ex,
                                            input int ey, input logic [31:0] color);
      req_type r;
      r.cmd         = OP_LOAD;
      r.start_x     = COORD_BITS'(sx);
      r.start_y     = COORD_BITS'(sy);
      r.end_x       = COORD_BITS'(ex);
      r.end_y       = COORD_BITS'(ey);
      r.pixel_color = color;
      return r;
   endfunction

   // Advance requests carry random junk in the unused fields; the block must
   // ignore it.
   function automatic req_type advance_request();
      req_type r;
      r.cmd         = OP_ADVANCE;
      r.start_x     = COORD_BITS'($urandom);
      r.start_y     = COORD_BITS'($urandom);
      r.end_x       = COORD_BITS'($urandom);
      r.end_y       = COORD_BITS'($urandom);
      r.pixel_color = $urandom;
      return r;
   endfunction

   // Pick a coordinate, biased toward the edges of the range.
   function automatic int pick_coord();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(0, 1) ? COORD_MAX : 0;
      return $urandom_range(0, COORD_MAX);
   endfunction

   // Offset a coordinate by d in a random direction, staying in range.
   function automatic int near(input int c, input int d);
      int v;
      v = $urandom_range(0, 1) ? c + d : c - d;
      if (v < 0 || v > COORD_MAX)
         v = (v < 0) ? c + d : c - d;
      return v;
   endfunction

   function automatic int major_span(input int sx, input int sy, input int ex, input int ey);
      int adx;
      int ady;
      adx = (ex > sx) ? ex - sx : sx - ex;
      ady = (ey > sy) ? ey - sy : sy - ey;
      return (adx > ady) ? adx : ady;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------
   // Offer one request and hold it until the block takes it. Random idle
   // bursts go in front of it unless the run is in its calm stretch.
   task automatic send_request(input req_type r);
      if (tx_mode_left == 0) begin
         tx_idling    = $urandom_range(0, 2) != 0;
         tx_mode_left = $urandom_range(20, 150);
      end else begin
         tx_mode_left--;
      end
      if (!calm && tx_idling && $urandom_range(0, 4) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_data <= r;
      push     <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   // Load a line, then walk it for the given number of advances. Extra
   // advances past the endpoint land on an idle block.
   task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                            input logic [31:0] color, input int advances);
      send_request(load_request(sx, sy, ex, ey, color));
      repeat (advances) send_request(advance_request());
      line_items += advances + 1;
   endtask

   // ---------------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------------
   // Drive pop once per cycle. A long hold-off, when requested, takes priority
   // so the result and command queues back up and full rises.
   initial begin : result_side
      int gap_left;
      int hold_left;
      int mode_left;
      bit rx_idling;
      gap_left  = 0;
      hold_left = 0;
      mode_left = 0;
      rx_idling = 1'b1;
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            pop <= 1'b0;
         end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left        = HOLD_CYCLES - 1;
            pop <= 1'b0;
         end else if (gap_left > 0) begin
            pop <= 1'b0;
            gap_left--;
         end else begin
            pop <= 1'b1;
            if (!calm && rx_idling && $urandom_range(0, 3) == 0)
               gap_left = $urandom_range(1, 9);
         end
         // Alternate between stretches with and without stalls.
         if (mode_left == 0) begin
            rx_idling = $urandom_range(0, 2) != 0;
            mode_left = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus and verdict
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      int          kind;
      int          sx;
      int          sy;
      int          ex;
      int          ey;
      int          major;
      int          advances;
      bit          pressure_done;
      logic [31:0] color;

      line_items       = 0;
      calm             = 1'b0;
      tx_idling        = 1'b1;
      tx_mode_left     = 0;
      hold_off_request = 1'b0;
      pressure_done    = 1'b0;
      reset    <= 1'b1;
      push     <= 1'b0;
      req_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part.
      // Advance straight out of reset: nothing is drawn.
      send_request(advance_request());
      // One-point lines at both corners, colors at both extremes.
      draw_line(0, 0, 0, 0, 32'h0000_0000, 0);
      draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF, 0);
      // Advance after a one-point line: the block is idle again.
      send_request(advance_request());
      // Full diagonal, equal deltas (x is major); abandon it after two steps.
      draw_line(0, 0, COORD_MAX, COORD_MAX, 32'hA5A5_5A5A, 2);
      // Anti-diagonal from the far corner, negative x step; abandon it too.
      draw_line(COORD_MAX, 0, 0, COORD_MAX, 32'h5A5A_A5A5, 2);
      // Horizontal line walked to the end, plus one advance while idle.
      draw_line(10, 20, 13, 20, 32'h1234_5678, 4);
      // Vertical line going up.
      draw_line(5, 9, 5, 6, 32'hFFFF_0000, 3);
      // Steep line with negative x step: exercises both error branches.
      draw_line(20, 10, 18, 15, 32'h0000_FFFF, 5);

      // Random part: mostly complete short lines with random content, with
      // some long lines cut short, early-abandoned lines and idle advances.
      while (line_items < ITEM_TARGET) begin
         if (line_items >= ITEM_TARGET - CALM_ITEMS)
            calm = 1'b1;
         if (!pressure_done && line_items >= 100) begin
            hold_off_request = 1'b1;
            pressure_done    = 1'b1;
         end
         kind  = $urandom_range(0, 19);
         color = $urandom;
         sx    = pick_coord();
         sy    = pick_coord();
         if (kind < 2) begin
            ex = $urandom_range(0, COORD_MAX);
            ey = $urandom_range(0, COORD_MAX);
         end else begin
            ex = near(sx, $urandom_range(0, 12));
            ey = near(sy, $urandom_range(0, 12));
         end
         major = major_span(sx, sy, ex, ey);
         if (kind == 0) begin
            advances = $urandom_range(5, 300);
            if (advances > major)
               advances = major;
         end else if (kind == 1 || kind == 2) begin
            advances = $urandom_range(0, (major > 8) ? 8 : major);
         end else begin
            advances = major;
         end
         draw_line(sx, sy, ex, ey, color, advances);
         // Poke the idle block after a finished line.
         if (kind > 16 && advances == major)
            repeat ($urandom_range(1, 3)) send_request(advance_request());
      end
      push <= 1'b0;

      // Drain: wait for every predicted pixel, then watch for strays.
      wait (pixels_pending == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
